@@ rtl/tcs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared codes and types for the text console with scrollback.
// ----------------------------------------------------------------------------
package tcs_pkg;

  // command codes
  localparam logic [1:0] CMD_PUT    = 2'd0;
  localparam logic [1:0] CMD_SCROLL = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  // control characters
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;

  // blank cell character and attribute after reset
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] RESET_ATTR = 8'd15;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_FILL = 3'b010,
    S_DONE = 3'b100
  } state_t;

endpackage

@@ rtl/tcs_cell_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_cell_ram
// Cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcs_cell_ram #(
  parameter int DEPTH = 20480,
  parameter int AW    = 15
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/tcs_cell_addr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_cell_addr
// Maps a logical line and column to a cell store address through the ring base.
// ----------------------------------------------------------------------------
module tcs_cell_addr #(
  parameter int LINES = 256,
  parameter int WIDTH = 80,
  localparam int LW = $clog2(LINES),
  localparam int CW = $clog2(WIDTH),
  localparam int AW = $clog2(LINES * WIDTH)
) (
  input  logic [LW-1:0] ring,
  input  logic [LW-1:0] line,
  input  logic [CW-1:0] col,
  output logic [AW-1:0] addr
);

  logic [LW:0]   phys_sum;
  logic [LW-1:0] phys;

  // ring offset, sum stays below twice LINES
  always_comb begin
    phys_sum = {1'b0, ring} + {1'b0, line};
    if (phys_sum >= LINES) begin
      phys = LW'(phys_sum - (LW+1)'(LINES));
    end else begin
      phys = phys_sum[LW-1:0];
    end
    addr = AW'(phys) * AW'(WIDTH) + AW'(col);
  end

endmodule

@@ rtl/text_console_scrollback.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_scrollback
// Character-cell console with a ring-organized scrollback cell store.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel (cmd_valid/cmd_ready) takes one item: put, scroll, clear
//   or read. Each item gives exactly one result item on the result channel
//   (res_valid/res_ready) with the read cell and the cursor/view status.
//   cfg_we/cfg_wdata write the blank attribute; write it only when idle.
// Timing:
//   put, scroll and read: the item waits in S_DONE until the output slot is
//   free, then its result is registered; the next item is taken after that
//   (a read waits on the store's read port; one item is in work at a time).
//   put that drops the oldest line: an S_FILL sweep of WIDTH cells blanks it.
//   clear: S_FILL sweeps all LINES*WIDTH cells, one cell written per cycle.
// Reset:
//   rst clears control state and starts a clearing pass of LINES*WIDTH cells
//   (20480 at default size) during which cmd_ready stays low.
// Stall:
//   A finished result waits in the output register while the next item is
//   accepted; that item's result holds in the sequencer until the slot frees.
// ----------------------------------------------------------------------------
module text_console_scrollback #(
  parameter int LINES  = 256,
  parameter int WIDTH  = 80,
  parameter int HEIGHT = 25
) (
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  // command channel
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  logic [1:0]        cmd,
  input  logic [7:0]        char_code,
  input  logic [7:0]        color,
  input  logic signed [9:0] scroll_lines,
  input  logic [4:0]        read_row,
  input  logic [6:0]        read_col,
  // result channel
  output logic              res_valid,
  input  logic              res_ready,
  output logic [7:0]        cell_char,
  output logic [7:0]        cell_attr,
  output logic [6:0]        cursor_col,
  output logic [7:0]        cursor_line,
  output logic [7:0]        view_offset,
  output logic              cursor_visible,
  output logic [10:0]       cursor_position
);

  import tcs_pkg::*;

  localparam int LW    = $clog2(LINES);
  localparam int CW    = $clog2(WIDTH);
  localparam int DEPTH = LINES * WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = ((LW > 10) ? LW : 10) + 2;
  localparam int PW    = LW + CW + 1;

  state_t        state;
  logic [LW-1:0] ring_base;
  logic [CW-1:0] cur_col;
  logic [LW-1:0] cur_line;
  logic [LW-1:0] top_line;
  logic [LW-1:0] content_end;
  logic [10:0]   last_pos;
  logic [7:0]    blank_attr;

  logic [AW-1:0] fill_addr;
  logic [AW-1:0] fill_end;
  logic [7:0]    fill_attr;
  logic          fill_cmd;
  logic          res_read;
  logic          rd_hit;

  logic          acc;
  logic          res_load;

  // put decode
  logic [CW:0]   pc;
  logic [LW:0]   pl;
  logic          put_we;
  logic [LW-1:0] put_line;
  logic [CW-1:0] put_col;
  logic [15:0]   put_data;
  logic          put_drop;
  logic [LW-1:0] ring_next;
  logic [CW-1:0] col_next;
  logic [LW-1:0] line_next;
  logic [LW-1:0] end_next;
  logic [LW-1:0] top_next;
  logic [AW-1:0] drop_base;

  // scroll
  logic signed [SW-1:0] scr_raw;
  logic signed [SW-1:0] scr_max;
  logic [LW-1:0]        scroll_top;

  // read
  logic [LW:0]   rline;
  logic          rd_ok;

  // status
  logic [LW-1:0] cur_diff;
  logic          vis;
  logic [10:0]   pos;

  // store ports
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] put_addr;
  logic [AW-1:0] rd_addr;
  logic [15:0]   rdata;

  assign cmd_ready = (state == S_IDLE);
  assign acc       = cmd_valid && cmd_ready;

  // output register loads once the item is done and the slot is free
  assign res_load  = (state == S_DONE) && (!res_valid || res_ready);

  // put: cursor motion, cell write, wrap and line drop
  always_comb begin
    pc       = {1'b0, cur_col};
    pl       = {1'b0, cur_line};
    put_we   = 1'b0;
    put_line = cur_line;
    put_col  = cur_col;
    put_data = {color, char_code};
    case (char_code)
      CH_NEWLINE: begin
        pc = '0;
        pl = pl + (LW+1)'(1);
      end
      CH_RETURN: begin
        pc = '0;
      end
      CH_BACKSPACE: begin
        if (cur_col != '0) begin
          pc = pc - (CW+1)'(1);
        end else if (cur_line != '0) begin
          pl = pl - (LW+1)'(1);
          pc = (CW+1)'(WIDTH - 1);
        end
        put_we   = 1'b1;
        put_line = pl[LW-1:0];
        put_col  = pc[CW-1:0];
        put_data = {color, SPACE_CHAR};
      end
      default: begin
        put_we = 1'b1;
        pc     = pc + (CW+1)'(1);
      end
    endcase
    if (pc >= WIDTH) begin
      pc = '0;
      pl = pl + (LW+1)'(1);
    end
    col_next = pc[CW-1:0];
    put_drop = (pl >= LINES);
    if (put_drop) begin
      line_next = LW'(LINES - 1);
      end_next  = LW'(LINES - 1);
      ring_next = (ring_base == LW'(LINES - 1)) ? '0 : ring_base + LW'(1);
    end else begin
      line_next = pl[LW-1:0];
      end_next  = (pl > {1'b0, content_end}) ? pl[LW-1:0] : content_end;
      ring_next = ring_base;
    end
    top_next  = (line_next > HEIGHT - 1) ? line_next - LW'(HEIGHT - 1) : '0;
    // dropped line lives at the old ring base
    drop_base = AW'(ring_base) * AW'(WIDTH);
  end

  // scroll: subtract and clamp to the content range
  always_comb begin
    scr_raw = $signed({{(SW-LW){1'b0}}, top_line}) - SW'(scroll_lines);
    scr_max = $signed({{(SW-LW){1'b0}}, content_end}) - SW'(HEIGHT - 1);
    if (scr_max < 0) begin
      scr_max = '0;
    end
    if (scr_raw < 0) begin
      scr_raw = '0;
    end
    if (scr_raw > scr_max) begin
      scr_raw = scr_max;
    end
    scroll_top = scr_raw[LW-1:0];
  end

  // read: visible cell to logical line, range check
  always_comb begin
    rline = {1'b0, top_line} + (LW+1)'(read_row);
    rd_ok = (read_row < HEIGHT) && (read_col < WIDTH) && (rline < LINES);
  end

  // cursor status after the command
  always_comb begin
    cur_diff = cur_line - top_line;
    vis      = (cur_line >= top_line) && (cur_diff < HEIGHT);
    pos      = 11'(PW'(cur_diff) * PW'(WIDTH) + PW'(cur_col));
  end

  tcs_cell_addr #(.LINES(LINES), .WIDTH(WIDTH)) u_put_addr (
    .ring (ring_base),
    .line (put_line),
    .col  (put_col),
    .addr (put_addr)
  );

  tcs_cell_addr #(.LINES(LINES), .WIDTH(WIDTH)) u_rd_addr (
    .ring (ring_base),
    .line (rline[LW-1:0]),
    .col  (CW'(read_col)),
    .addr (rd_addr)
  );

  // store port muxing: sweep owns the write port while filling
  always_comb begin
    mem_we    = (state == S_FILL) || (acc && (cmd == CMD_PUT) && put_we);
    mem_waddr = (state == S_FILL) ? fill_addr : put_addr;
    mem_wdata = (state == S_FILL) ? {fill_attr, SPACE_CHAR} : put_data;
    mem_re    = acc && (cmd == CMD_READ);
  end

  tcs_cell_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // sequencer and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_FILL;
      fill_addr   <= '0;
      fill_end    <= AW'(DEPTH - 1);
      fill_attr   <= RESET_ATTR;
      fill_cmd    <= 1'b0;
      blank_attr  <= RESET_ATTR;
      ring_base   <= '0;
      cur_col     <= '0;
      cur_line    <= '0;
      top_line    <= '0;
      content_end <= '0;
      last_pos    <= '0;
      res_valid   <= 1'b0;
      res_read    <= 1'b0;
      rd_hit      <= 1'b0;
    end else begin
      if (cfg_we) begin
        blank_attr <= cfg_wdata;
      end
      // result slot: load a finished item or free it on handoff
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc) begin
            res_read <= (cmd == CMD_READ);
            rd_hit   <= rd_ok;
            case (cmd)
              CMD_PUT: begin
                cur_col     <= col_next;
                cur_line    <= line_next;
                content_end <= end_next;
                top_line    <= top_next;
                ring_base   <= ring_next;
                if (put_drop) begin
                  fill_addr <= drop_base;
                  fill_end  <= drop_base + AW'(WIDTH - 1);
                  fill_attr <= blank_attr;
                  fill_cmd  <= 1'b1;
                  state     <= S_FILL;
                end else begin
                  state <= S_DONE;
                end
              end
              CMD_SCROLL: begin
                top_line <= scroll_top;
                state    <= S_DONE;
              end
              CMD_CLEAR: begin
                ring_base   <= '0;
                cur_col     <= '0;
                cur_line    <= '0;
                top_line    <= '0;
                content_end <= '0;
                fill_addr   <= '0;
                fill_end    <= AW'(DEPTH - 1);
                fill_attr   <= blank_attr;
                fill_cmd    <= 1'b1;
                state       <= S_FILL;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_FILL: begin
          fill_addr <= fill_addr + AW'(1);
          if (fill_addr == fill_end) begin
            state <= fill_cmd ? S_DONE : S_IDLE;
          end
        end
        S_DONE: begin
          // hand the result to the output register once it is free
          if (res_load) begin
            cell_char      <= !res_read ? 8'd0 : (rd_hit ? rdata[7:0] : SPACE_CHAR);
            cell_attr      <= !res_read ? 8'd0 : (rd_hit ? rdata[15:8] : blank_attr);
            cursor_col     <= 7'(cur_col);
            cursor_line    <= 8'(cur_line);
            view_offset    <= 8'(top_line);
            cursor_visible <= vis;
            cursor_position <= vis ? pos : last_pos;
            if (vis) begin
              last_pos <= pos;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/tcs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_checker
// Port-level checks for the console, bound to the top level.
// ----------------------------------------------------------------------------
module tcs_checker (
  input logic              clk,
  input logic              rst,
  input logic              cfg_we,
  input logic [7:0]        cfg_wdata,
  input logic              cmd_valid,
  input logic              cmd_ready,
  input logic [1:0]        cmd,
  input logic [7:0]        char_code,
  input logic [7:0]        color,
  input logic signed [9:0] scroll_lines,
  input logic [4:0]        read_row,
  input logic [6:0]        read_col,
  input logic              res_valid,
  input logic              res_ready,
  input logic [7:0]        cell_char,
  input logic [7:0]        cell_attr,
  input logic [6:0]        cursor_col,
  input logic [7:0]        cursor_line,
  input logic [7:0]        view_offset,
  input logic              cursor_visible,
  input logic [10:0]       cursor_position
);

  // stalled result item holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(cell_char) && $stable(cell_attr)
      && $stable(cursor_col) && $stable(cursor_line) && $stable(view_offset)
      && $stable(cursor_visible) && $stable(cursor_position))
    else $error("result item changed while stalled");

  // reset empties the output and starts the clearing pass
  a_reset: assert property (@(posedge clk)
    rst |=> !res_valid && !cmd_ready)
    else $error("reset did not block commands or clear the result");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken in the cycle after an accept");

endmodule

bind text_console_scrollback tcs_checker u_tcs_checker (.*);
